[hw/rtl/stfcen_pkg.sv]
// Shared widths, constants and helpers for the stiffness ratio census.
package stfcen_pkg;

  // Counter and position widths
  localparam int CNT_W = 21;
  localparam int IDX_W = 22;

  // Q2.30 ratio width and quotient steps of the divider
  localparam int Q_W      = 32;
  localparam int DIV_BITS = 31;
  localparam int STEP_W   = $clog2(DIV_BITS);

  // Counter ceiling
  localparam logic [CNT_W-1:0] MAX_NODES = CNT_W'(1048576);

  // Ratio of 2.0, also the empty-census minimum
  localparam logic [Q_W-1:0] Q_TWO = 32'h8000_0000;

  // Threshold reset values (about 1e-3, 1e-2, 1e-1)
  localparam logic [Q_W-1:0] TIGHT_RESET  = 32'd1073742;
  localparam logic [Q_W-1:0] MIDDLE_RESET = 32'd10737418;
  localparam logic [Q_W-1:0] LOOSE_RESET  = 32'd107374182;

  // Configuration register indexes
  localparam logic [1:0] REG_TIGHT  = 2'd0;
  localparam logic [1:0] REG_MIDDLE = 2'd1;
  localparam logic [1:0] REG_LOOSE  = 2'd2;

  // Increment that stops at the counter ceiling
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v < MAX_NODES) ? v + CNT_W'(1) : MAX_NODES;
  endfunction

endpackage

[hw/rtl/stiffness_ratio_census.sv]
// Top level of the stiffness ratio census: bit-serial divider and accumulators.
//
// Usage:
//   The input channel (in_valid / in_ready) takes one node per beat: its current
//   and reference diagonals, an enable bit and a last-node flag. The output
//   channel (out_valid / out_ready) delivers one census beat for each beat
//   that carries last_node. Threshold registers are written through cfg_write,
//   cfg_index and cfg_data while the block is idle; other indexes are ignored.
// Sequence:
//   A node whose ratio must be formed is accepted, then passes through the
//   restoring divider (one quotient bit per cycle, integer bit first) and
//   then updates the counters. Masked, unreferenced, non-positive and
//   saturated nodes go from acceptance straight to the update step. The census
//   appears on the output in the cycle after the update of the last node.
// Reset and stalls:
//   rst clears all counters, sets the minimum to 2.0 with position -1 and
//   restores the default thresholds. A finished census waits in the output
//   register; the block keeps taking nodes and only holds in its update step
//   when a second census is ready before the first one has been taken.
module stiffness_ratio_census
  import stfcen_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // Configuration
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [Q_W-1:0]          cfg_data,
  // Node input
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [31:0]      diag_now,
  input  logic signed [31:0]      diag_reference,
  input  logic                    node_enabled,
  input  logic                    last_node,
  // Census output
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CNT_W-1:0]        nodes_counted,
  output logic [CNT_W-1:0]        below_tight_count,
  output logic [CNT_W-1:0]        below_middle_count,
  output logic [CNT_W-1:0]        below_loose_count,
  output logic [CNT_W-1:0]        nonpositive_count,
  output logic signed [IDX_W-1:0] worst_node,
  output logic [Q_W-1:0]          worst_ratio
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_UPDATE} state_t;

  state_t state;

  // Thresholds
  logic [Q_W-1:0] tight_threshold;
  logic [Q_W-1:0] middle_threshold;
  logic [Q_W-1:0] loose_threshold;

  // Census state
  logic [CNT_W-1:0]        position;
  logic [CNT_W-1:0]        counted_acc;
  logic [CNT_W-1:0]        tight_acc;
  logic [CNT_W-1:0]        middle_acc;
  logic [CNT_W-1:0]        loose_acc;
  logic [CNT_W-1:0]        nonpositive_acc;
  logic signed [IDX_W-1:0] worst_index;
  logic [Q_W-1:0]          worst_value;

  // Node in flight
  logic              hit_counted;
  logic              hit_nonpos;
  logic              hit_compare;
  logic              last_r;
  logic [Q_W-1:0]    rem;
  logic [30:0]       den;
  logic [Q_W-1:0]    ratio;
  logic [STEP_W-1:0] step;

  // Classify the incoming node
  logic ref_pos;
  logic now_pos;
  logic in_counted;
  logic in_sat;
  logic in_fire;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign ref_pos    = !diag_reference[31] && (diag_reference[30:0] != 31'd0);
  assign now_pos    = !diag_now[31] && (diag_now[30:0] != 31'd0);
  assign in_counted = node_enabled && ref_pos;
  assign in_sat     = {2'b00, diag_now[30:0]} >= {1'b0, diag_reference[30:0], 1'b0};

  // One restoring division step
  logic           div_ge;
  logic [Q_W-1:0] div_diff;

  assign div_ge   = rem >= {1'b0, den};
  assign div_diff = rem - {1'b0, den};

  // Census values after the node in flight
  logic [CNT_W-1:0]        position_next;
  logic [CNT_W-1:0]        counted_next;
  logic [CNT_W-1:0]        tight_next;
  logic [CNT_W-1:0]        middle_next;
  logic [CNT_W-1:0]        loose_next;
  logic [CNT_W-1:0]        nonpositive_next;
  logic signed [IDX_W-1:0] worst_index_next;
  logic [Q_W-1:0]          worst_value_next;
  logic                    hold;
  logic                    emit;

  always_comb begin
    position_next    = sat_inc(position);
    counted_next     = hit_counted ? sat_inc(counted_acc) : counted_acc;
    nonpositive_next = hit_nonpos ? sat_inc(nonpositive_acc) : nonpositive_acc;
    tight_next       = (hit_compare && ratio < tight_threshold) ? sat_inc(tight_acc)
                                                                : tight_acc;
    middle_next      = (hit_compare && ratio < middle_threshold) ? sat_inc(middle_acc)
                                                                 : middle_acc;
    loose_next       = (hit_compare && ratio < loose_threshold) ? sat_inc(loose_acc)
                                                                : loose_acc;
    worst_index_next = worst_index;
    worst_value_next = worst_value;
    if (hit_compare && ratio < worst_value) begin
      worst_value_next = ratio;
      worst_index_next = {1'b0, position_next};
    end
  end

  // Hold the update of a last node while an earlier census still waits
  assign hold = last_r && out_valid && !out_ready;

  // A census leaves the update step this cycle
  assign emit = (state == S_UPDATE) && last_r && !hold;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tight_threshold  <= TIGHT_RESET;
      middle_threshold <= MIDDLE_RESET;
      loose_threshold  <= LOOSE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIGHT:  tight_threshold  <= cfg_data;
        REG_MIDDLE: middle_threshold <= cfg_data;
        REG_LOOSE:  loose_threshold  <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Sequencer, divider, accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      position        <= '0;
      counted_acc     <= '0;
      tight_acc       <= '0;
      middle_acc      <= '0;
      loose_acc       <= '0;
      nonpositive_acc <= '0;
      worst_index     <= '1;
      worst_value     <= Q_TWO;
      hit_counted     <= 1'b0;
      hit_nonpos      <= 1'b0;
      hit_compare     <= 1'b0;
      last_r          <= 1'b0;
      step            <= '0;
    end else begin
      // Drop the census once taken, unless a new one replaces it
      if (out_valid && out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            hit_counted <= in_counted;
            hit_nonpos  <= in_counted && !now_pos;
            hit_compare <= in_counted && now_pos;
            last_r      <= last_node;
            rem         <= {1'b0, diag_now[30:0]};
            den         <= diag_reference[30:0];
            step        <= '0;
            if (in_counted && now_pos && !in_sat) begin
              ratio <= '0;
              state <= S_DIV;
            end else begin
              ratio <= Q_TWO;
              state <= S_UPDATE;
            end
          end
        end
        S_DIV: begin
          // Advance one quotient bit, integer bit first
          rem   <= div_ge ? {div_diff[30:0], 1'b0} : {rem[30:0], 1'b0};
          ratio <= {1'b0, ratio[29:0], div_ge};
          step  <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_BITS - 1)) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (!hold) begin
            state <= S_IDLE;
            if (last_r) begin
              // Emit the census and clear
              out_valid          <= 1'b1;
              nodes_counted      <= counted_next;
              below_tight_count  <= tight_next;
              below_middle_count <= middle_next;
              below_loose_count  <= loose_next;
              nonpositive_count  <= nonpositive_next;
              worst_node         <= worst_index_next;
              worst_ratio        <= worst_value_next;
              position           <= '0;
              counted_acc        <= '0;
              tight_acc          <= '0;
              middle_acc         <= '0;
              loose_acc          <= '0;
              nonpositive_acc    <= '0;
              worst_index        <= '1;
              worst_value        <= Q_TWO;
            end else begin
              position        <= position_next;
              counted_acc     <= counted_next;
              tight_acc       <= tight_next;
              middle_acc      <= middle_next;
              loose_acc       <= loose_next;
              nonpositive_acc <= nonpositive_next;
              worst_index     <= worst_index_next;
              worst_value     <= worst_value_next;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/stfcen_checker.sv]
// Port-level checks of the stiffness ratio census, bound to the top level.
module stfcen_checker
  import stfcen_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CNT_W-1:0]        nodes_counted,
  input logic [CNT_W-1:0]        below_tight_count,
  input logic [CNT_W-1:0]        below_middle_count,
  input logic [CNT_W-1:0]        below_loose_count,
  input logic [CNT_W-1:0]        nonpositive_count,
  input logic signed [IDX_W-1:0] worst_node,
  input logic [Q_W-1:0]          worst_ratio
);

  // A stalled census holds its beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(worst_ratio) && $stable(worst_node))
    else $error("census changed while stalled");

  // Each node keeps the block busy in the cycle after its beat
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // No position exactly when the minimum stayed at 2.0
  a_worst_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((worst_node == -22'sd1) == (worst_ratio == Q_TWO)))
    else $error("worst position and ratio disagree");

  // Sub-counts never pass the node count
  a_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> nonpositive_count <= nodes_counted && below_tight_count <= nodes_counted
              && below_middle_count <= nodes_counted && below_loose_count <= nodes_counted)
    else $error("sub-count exceeds node count");

  // The node count stays within the ceiling
  a_ceiling: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> nodes_counted <= MAX_NODES)
    else $error("node count beyond ceiling");

endmodule

bind stiffness_ratio_census stfcen_checker u_stfcen_checker (.*);

[tb/stiffness_ratio_census_checker.sv]
// Checker for the stiffness ratio census: tracks thresholds, predicts each census, compares beats.
`timescale 1ns / 1ps
module stiffness_ratio_census_checker
  import stfcen_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [Q_W-1:0]          cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [31:0]      diag_now,
  input  logic signed [31:0]      diag_reference,
  input  logic                    node_enabled,
  input  logic                    last_node,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [CNT_W-1:0]        nodes_counted,
  input  logic [CNT_W-1:0]        below_tight_count,
  input  logic [CNT_W-1:0]        below_middle_count,
  input  logic [CNT_W-1:0]        below_loose_count,
  input  logic [CNT_W-1:0]        nonpositive_count,
  input  logic signed [IDX_W-1:0] worst_node,
  input  logic [Q_W-1:0]          worst_ratio,
  output int                      failures,
  output int                      pending
);

  typedef struct {
    logic [CNT_W-1:0]        counted;
    logic [CNT_W-1:0]        tight;
    logic [CNT_W-1:0]        middle;
    logic [CNT_W-1:0]        loose;
    logic [CNT_W-1:0]        nonpos;
    logic signed [IDX_W-1:0] worst_pos;
    logic [Q_W-1:0]          worst_q;
  } census_t;

  // Censuses predicted but not yet seen on the output
  census_t census_q[$];

  // Threshold copies
  logic [Q_W-1:0] tight_lim, middle_lim, loose_lim;

  // Running census of the nodes seen so far
  logic [CNT_W-1:0]        node_pos, counted_n, tight_n, middle_n, loose_n, nonpos_n;
  logic signed [IDX_W-1:0] worst_pos_n;
  logic [Q_W-1:0]          worst_q_n;

  // Count up, stopping at the node ceiling
  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v < MAX_NODES) ? v + 1'b1 : MAX_NODES;
  endfunction

  // Truncated quotient of two positive diagonals in Q2.30, held at 2.0
  function automatic logic [Q_W-1:0] ratio_q230(input logic [30:0] num, input logic [30:0] den);
    longint unsigned q;
    if ({1'b0, num} >= {den, 1'b0}) return Q_TWO;
    q = (longint'(num) << 30) / longint'(den);
    return (q >= longint'(Q_TWO)) ? Q_TWO : q[Q_W-1:0];
  endfunction

  task automatic clear_census();
    node_pos    = '0;
    counted_n   = '0;
    tight_n     = '0;
    middle_n    = '0;
    loose_n     = '0;
    nonpos_n    = '0;
    worst_pos_n = '1;
    worst_q_n   = Q_TWO;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    census_t want;
    logic [Q_W-1:0] r;
    if (rst) begin
      tight_lim  = TIGHT_RESET;
      middle_lim = MIDDLE_RESET;
      loose_lim  = LOOSE_RESET;
      clear_census();
      census_q.delete();
    end else begin
      // Track register writes; unknown indexes are dropped
      if (cfg_write) begin
        case (cfg_index)
          REG_TIGHT:  tight_lim  = cfg_data;
          REG_MIDDLE: middle_lim = cfg_data;
          REG_LOOSE:  loose_lim  = cfg_data;
          default: ;
        endcase
      end

      // Compare a census beat with the oldest prediction
      if (out_valid && out_ready) begin
        if (census_q.size() == 0) begin
          failures++;
          $display("%0t: census beat expected none actual counted %h worst %h", $time,
                   nodes_counted, worst_ratio);
        end else begin
          want = census_q.pop_front();
          check_field("nodes_counted", 32'(want.counted), 32'(nodes_counted));
          check_field("below_tight_count", 32'(want.tight), 32'(below_tight_count));
          check_field("below_middle_count", 32'(want.middle), 32'(below_middle_count));
          check_field("below_loose_count", 32'(want.loose), 32'(below_loose_count));
          check_field("nonpositive_count", 32'(want.nonpos), 32'(nonpositive_count));
          check_field("worst_node", 32'(want.worst_pos), 32'(worst_node));
          check_field("worst_ratio", want.worst_q, worst_ratio);
        end
      end

      // Advance the running census on each node beat
      if (in_valid && in_ready) begin
        node_pos = bump(node_pos);
        if (node_enabled && diag_reference > 0) begin
          counted_n = bump(counted_n);
          if (diag_now <= 0) begin
            nonpos_n = bump(nonpos_n);
          end else begin
            r = ratio_q230(diag_now[30:0], diag_reference[30:0]);
            if (r < tight_lim) tight_n = bump(tight_n);
            if (r < middle_lim) middle_n = bump(middle_n);
            if (r < loose_lim) loose_n = bump(loose_n);
            // Strictly smaller only, so the earlier node wins a tie
            if (r < worst_q_n) begin
              worst_q_n   = r;
              worst_pos_n = IDX_W'(node_pos);
            end
          end
        end
        if (last_node) begin
          census_q.push_back('{counted_n, tight_n, middle_n, loose_n, nonpos_n,
                               worst_pos_n, worst_q_n});
          clear_census();
        end
      end
    end
    pending = census_q.size();
  end

endmodule

[tb/stiffness_ratio_census_tb.sv]
// Testbench top for the stiffness ratio census: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module stiffness_ratio_census_tb;
  import stfcen_pkg::*;

  localparam logic [1:0] REG_UNUSED    = 2'd3;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         PHASE_NODES   = 135;

  logic                    clk            = 1'b0;
  logic                    rst            = 1'b1;
  logic                    cfg_write      = 1'b0;
  logic [1:0]              cfg_index      = REG_TIGHT;
  logic [Q_W-1:0]          cfg_data       = '0;
  logic                    in_valid       = 1'b0;
  logic signed [31:0]      diag_now       = '0;
  logic signed [31:0]      diag_reference = '0;
  logic                    node_enabled   = 1'b0;
  logic                    last_node      = 1'b0;
  logic                    out_ready      = 1'b0;
  logic                    in_ready;
  logic                    out_valid;
  logic [CNT_W-1:0]        nodes_counted;
  logic [CNT_W-1:0]        below_tight_count;
  logic [CNT_W-1:0]        below_middle_count;
  logic [CNT_W-1:0]        below_loose_count;
  logic [CNT_W-1:0]        nonpositive_count;
  logic signed [IDX_W-1:0] worst_node;
  logic [Q_W-1:0]          worst_ratio;

  int   failures;
  int   pending;
  int   cycles = 0;
  // Set for a census to run both sides without idling
  logic steady = 1'b0;

  always #2 clk = ~clk;

  stiffness_ratio_census uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .diag_now(diag_now), .diag_reference(diag_reference),
    .node_enabled(node_enabled), .last_node(last_node),
    .out_valid(out_valid), .out_ready(out_ready),
    .nodes_counted(nodes_counted), .below_tight_count(below_tight_count),
    .below_middle_count(below_middle_count), .below_loose_count(below_loose_count),
    .nonpositive_count(nonpositive_count), .worst_node(worst_node),
    .worst_ratio(worst_ratio)
  );

  stiffness_ratio_census_checker census_chk (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .diag_now(diag_now), .diag_reference(diag_reference),
    .node_enabled(node_enabled), .last_node(last_node),
    .out_valid(out_valid), .out_ready(out_ready),
    .nodes_counted(nodes_counted), .below_tight_count(below_tight_count),
    .below_middle_count(below_middle_count), .below_loose_count(below_loose_count),
    .nonpositive_count(nonpositive_count), .worst_node(worst_node),
    .worst_ratio(worst_ratio),
    .failures(failures), .pending(pending)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("stiffness_ratio_census test failed");
      $finish;
    end
  end

  // Offer one node beat after a random gap and hold it until taken
  task automatic send_node(input logic signed [31:0] now, input logic signed [31:0] base,
                           input logic en, input logic fin);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    diag_now       <= now;
    diag_reference <= base;
    node_enabled   <= en;
    last_node      <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every census, then let the block settle
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the three thresholds, then a write to the unused index
  task automatic program_thresholds(input logic [Q_W-1:0] t, input logic [Q_W-1:0] m,
                                    input logic [Q_W-1:0] l);
    logic [1:0]     idx [4];
    logic [Q_W-1:0] val [4];
    idx = '{REG_TIGHT, REG_MIDDLE, REG_LOOSE, REG_UNUSED};
    val = '{t, m, l, $urandom};
    for (int k = 0; k < 4; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Random censuses: mostly nodes with a chosen ratio, some raw noise
  task automatic run_random_censuses(input int budget);
    int                 sent, len, kind;
    longint             base_l, now_l, target;
    logic signed [31:0] now_v, base_v;
    logic               en;
    sent = 0;
    while (sent < budget) begin
      len    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      steady = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
        kind = $urandom_range(0, 9);
        en   = ($urandom_range(0, 9) != 0);
        if (kind < 2) begin
          now_v  = $urandom;
          base_v = $urandom;
          en     = 1'($urandom_range(0, 1));
        end else if (kind == 2) begin
          now_v  = $urandom_range(0, 24) - 4;
          base_v = $urandom_range(0, 24) - 4;
        end else begin
          // Pick a reference of random magnitude and a log-spread ratio
          base_l = longint'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 30));
          if (base_l == 0) base_l = 1;
          target = longint'($urandom >> $urandom_range(0, 31));
          now_l  = (base_l * target) >> 30;
          if ($urandom_range(0, 3) == 0) now_l = now_l + $urandom_range(0, 2) - 1;
          if (now_l > 64'sd2147483647) now_l = 64'sd2147483647;
          now_v  = now_l[31:0];
          base_v = base_l[31:0];
        end
        send_node(now_v, base_v, en, i == len - 1);
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  // Receive side: random stall before each census beat
  initial begin
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [Q_W-1:0] t_set [6];
    logic [Q_W-1:0] m_set [6];
    logic [Q_W-1:0] l_set [6];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes, skips and non-positive nodes; masked last item
    send_node(32'sd1, 32'sd1, 1'b1, 1'b0);
    send_node(32'sd0, 32'sd5, 1'b1, 1'b0);
    send_node(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_node(32'h7FFF_FFFF, 32'sd1, 1'b1, 1'b0);
    send_node(32'sd1, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_node(32'sd1, 32'sd1000, 1'b0, 1'b0);
    send_node(32'sd5, 32'sd0, 1'b1, 1'b0);
    send_node(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1);
    // Ratio ties, exact 2.0 and near 2.0
    send_node(32'sd3, 32'sd6, 1'b1, 1'b0);
    send_node(32'sd7, 32'sd14, 1'b1, 1'b0);
    send_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_node(32'sd10, 32'sd5, 1'b1, 1'b0);
    send_node(32'sd19, 32'sd10, 1'b1, 1'b0);
    send_node(32'sd1, 32'sd2, 1'b0, 1'b1);
    // One-node census and an empty census
    send_node(32'sd1, 32'sd1, 1'b1, 1'b1);
    send_node(32'sd4, 32'sd4, 1'b0, 1'b1);
    // Ratios just below and exactly at each default threshold
    send_node(32'sd1073741, 32'h4000_0000, 1'b1, 1'b0);
    send_node(32'sd1073742, 32'h4000_0000, 1'b1, 1'b0);
    send_node(32'sd10737417, 32'h4000_0000, 1'b1, 1'b0);
    send_node(32'sd10737418, 32'h4000_0000, 1'b1, 1'b0);
    send_node(32'sd107374181, 32'h4000_0000, 1'b1, 1'b0);
    send_node(32'sd107374182, 32'h4000_0000, 1'b1, 1'b1);

    run_random_censuses(PHASE_NODES);
    drain_and_settle();

    // Threshold settings: none below, all below, 2.0, mixed, random
    t_set = '{32'h0, 32'hFFFF_FFFF, Q_TWO, 32'h1, $urandom, $urandom};
    m_set = '{32'h0, 32'hFFFF_FFFF, Q_TWO, 32'h4000_0000, $urandom, $urandom >> 4};
    l_set = '{32'h0, 32'hFFFF_FFFF, Q_TWO, 32'h7FFF_FFFF, $urandom, $urandom >> 8};
    for (int p = 0; p < 6; p++) begin
      program_thresholds(t_set[p], m_set[p], l_set[p]);
      run_random_censuses(PHASE_NODES);
      drain_and_settle();
    end

    if (failures == 0 && pending == 0) begin
      $display("stiffness_ratio_census test passed");
    end else begin
      $display("stiffness_ratio_census test failed");
    end
    $finish;
  end

endmodule
